### sv/pee_pkg.sv
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, codes, command and status types and fixed-point helpers.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int FRAC_BITS   = 24;
   localparam int DATA_W      = 64;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DCNT_W      = $clog2(PROD_W + 2);

   localparam logic [DATA_W-1:0] FX_ONE    = 64'd1 << FRAC_BITS;
   localparam logic [DATA_W-1:0] FRAC_MASK = FX_ONE - 64'd1;
   localparam logic [PROD_W-1:0] MUL_RND   = (128'd1 << FRAC_BITS) >> 1;
   localparam logic [DATA_W-1:0] S_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] S_MAX     = {1'b0, {(DATA_W-1){1'b1}}};

   localparam logic [7:0] SYM_ZERO   = 8'h30;
   localparam logic [7:0] SYM_NINE   = 8'h39;
   localparam logic [7:0] SYM_PLUS   = 8'h2B;
   localparam logic [7:0] SYM_MINUS  = 8'h2D;
   localparam logic [7:0] SYM_STAR   = 8'h2A;
   localparam logic [7:0] SYM_SLASH  = 8'h2F;
   localparam logic [7:0] SYM_DOLLAR = 8'h24;

   typedef enum logic [2:0] {
      ST_OK, ST_UNDERFLOW, ST_ILLEGAL, ST_DIV_ZERO, ST_SATURATED, ST_OVERFLOW,
      ST_FRAC_EXP
   } status_type;

   typedef enum logic [2:0] {K_ADD, K_SUB, K_MUL, K_DIV, K_POW, K_BAD} kind_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_PUSH, CMD_ERR, CMD_RD_B, CMD_RD_A, CMD_LATCH_A,
      CMD_ADD, CMD_SUB, CMD_MUL_AB, CMD_DIV_AB, CMD_POW_INIT, CMD_MUL_ACC,
      CMD_MUL_SQ, CMD_TAKE_MRES, CMD_TAKE_DRES, CMD_TAKE_ACC, CMD_TAKE_SQ,
      CMD_NM_SHIFT, CMD_DIV_POW, CMD_ACC_RES, CMD_WRB, CMD_RD_TOP, CMD_LATCH_TOP,
      CMD_OUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic     hard;
      logic     digit;
      logic     full;
      logic     lt2;
      logic     cnt_zero;
      logic     last;
      kind_type kind;
      logic     b_zero;
      logic     e_frac;
      logic     mul_busy;
      logic     div_busy;
      logic     nm_zero;
      logic     nm_odd;
      logic     nm_one;
      logic     n_neg;
      logic     acc_zero;
   } stat_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic              sat;
   } pack_type;

   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
      mag = x[DATA_W-1] ? (64'd0 - x) : x;
   endfunction

   // Signed value from sign and 128-bit magnitude, clamped to 64 bits.
   function automatic pack_type sat_pack(input logic neg, input logic [PROD_W-1:0] q);
      pack_type p;
      logic     big;
      big = |q[PROD_W-1:DATA_W];
      if (neg) begin
         p.sat = big || (q[DATA_W-1] && (|q[DATA_W-2:0]));
         p.val = p.sat ? S_MIN : (64'd0 - q[DATA_W-1:0]);
      end else begin
         p.sat = big || q[DATA_W-1];
         p.val = p.sat ? S_MAX : q[DATA_W-1:0];
      end
      sat_pack = p;
   endfunction

endpackage

### sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates postfix expressions in signed 64-bit fixed point, one symbol
// per request, and returns one result per expression.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                           Direction  Contents
//   req      req_valid/ready, symbol, last   in         one ASCII symbol
//   rsp      rsp_valid/ready, value, status  out        result of an expression
//
// A multiply runs in the shared multiplier, which forms four 32x32 partial
// products. A divide runs in the divider, which resolves one quotient bit
// per cycle over a 128-bit numerator. A power costs one squaring per
// exponent bit above the lowest plus one multiply per set bit, and a divide
// if the exponent is negative. On the final symbol the top of the stack is
// read and passed to the output register.
// Reset is synchronous and active high; it empties the stack and clears the
// error. The stack memory itself is not cleared. A result waiting in the
// output register does not block the next request; only a second result
// holds the controller until the first is taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pee_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_symbol,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status
);

   // The controller issues one command per cycle; the datapath answers
   // with a status word that carries decode results and unit busy flags.
   cmd_type  cmd;
   stat_type stat;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule

### sv/pee_dp.sv
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Operand stack, registers, shared multiplier and shift-subtract divider.
// ----------------------------------------------------------------------------
module pee_dp import pee_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_symbol,
   input  logic                     req_last,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status
);

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_ff;

   logic [7:0]        sym_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  count_ff;
   status_type        err_ff;
   logic [DATA_W-1:0] a_ff, b_ff, res_ff, acc_ff, sq_ff, nm_ff;
   logic              nneg_ff, sat_ff;
   logic [DATA_W-1:0] value_ff;
   status_type        status_ff;

   // Multiplier: four 32x32 partial products, then rounding and clamping.
   logic [DATA_W-1:0] mx_ff, my_ff, pp_ff, mres_ff;
   logic              mneg_ff, mbusy_ff, mpv_ff;
   logic [2:0]        mphase_ff;
   logic [1:0]        psh_ff;
   logic [PROD_W-1:0] macc_ff;

   // Divider: one quotient bit per cycle.
   logic [DATA_W-1:0] nb_ff, rem_ff, dres_ff;
   logic [PROD_W-1:0] num_ff;
   logic              dneg_ff, dbusy_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   logic [CNT_W-1:0]  cm1, cm2;
   logic              hard;
   kind_type          kind;
   logic [DATA_W-1:0] sum, dif, mx_sel, my_sel, dx_sel, dy_sel, n_val;
   logic              add_ovf, sub_ovf;
   logic [31:0]       xh, yh;
   logic [DATA_W-1:0] pp_in;
   logic [PROD_W-1:0] pp_sh;
   logic [DATA_W:0]   r2;
   logic              ge;
   pack_type          pk_m, pk_d;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data;

   assign cm1  = count_ff - CNT_W'(1);
   assign cm2  = count_ff - CNT_W'(2);
   assign hard = (err_ff != ST_OK) && (err_ff != ST_SATURATED);

   always_comb begin
      unique case (sym_ff)
         SYM_PLUS:   kind = K_ADD;
         SYM_MINUS:  kind = K_SUB;
         SYM_STAR:   kind = K_MUL;
         SYM_SLASH:  kind = K_DIV;
         SYM_DOLLAR: kind = K_POW;
         default:    kind = K_BAD;
      endcase
   end

   always_comb begin
      stat.hard     = hard;
      stat.digit    = (sym_ff >= SYM_ZERO) && (sym_ff <= SYM_NINE);
      stat.full     = count_ff >= CNT_W'(STACK_DEPTH);
      stat.lt2      = count_ff < CNT_W'(2);
      stat.cnt_zero = count_ff == '0;
      stat.last     = last_ff;
      stat.kind     = kind;
      stat.b_zero   = b_ff == '0;
      stat.e_frac   = (b_ff & FRAC_MASK) != '0;
      stat.mul_busy = mbusy_ff;
      stat.div_busy = dbusy_ff;
      stat.nm_zero  = nm_ff == '0;
      stat.nm_odd   = nm_ff[0];
      stat.nm_one   = nm_ff[DATA_W-1:1] == '0;
      stat.n_neg    = nneg_ff;
      stat.acc_zero = acc_ff == '0;
   end

   assign sum     = a_ff + b_ff;
   assign dif     = a_ff - b_ff;
   assign add_ovf = (a_ff[DATA_W-1] == b_ff[DATA_W-1]) && (sum[DATA_W-1] != a_ff[DATA_W-1]);
   assign sub_ovf = (a_ff[DATA_W-1] != b_ff[DATA_W-1]) && (dif[DATA_W-1] != a_ff[DATA_W-1]);
   assign n_val   = $signed(b_ff) >>> FRAC_BITS;

   always_comb begin
      unique case (cmd.op)
         CMD_MUL_AB:  begin mx_sel = a_ff;   my_sel = b_ff; end
         CMD_MUL_ACC: begin mx_sel = acc_ff; my_sel = sq_ff; end
         default:     begin mx_sel = sq_ff;  my_sel = sq_ff; end
      endcase
      if (cmd.op == CMD_DIV_AB) begin
         dx_sel = a_ff;
         dy_sel = b_ff;
      end else begin
         dx_sel = FX_ONE;
         dy_sel = acc_ff;
      end
   end

   assign xh    = mphase_ff[1] ? mx_ff[DATA_W-1:32] : mx_ff[31:0];
   assign yh    = mphase_ff[0] ? my_ff[DATA_W-1:32] : my_ff[31:0];
   assign pp_in = {32'd0, xh} * {32'd0, yh};

   always_comb begin
      unique case (psh_ff)
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd1:    pp_sh = {32'd0, pp_ff, 32'd0};
         default: pp_sh = {pp_ff, 64'd0};
      endcase
   end

   assign pk_m = sat_pack(mneg_ff, macc_ff >> FRAC_BITS);
   assign pk_d = sat_pack(dneg_ff, num_ff);
   assign r2   = {rem_ff, num_ff[PROD_W-1]};
   assign ge   = r2 >= {1'b0, nb_ff};

   always_comb begin
      wr_en   = (cmd.op == CMD_PUSH) || (cmd.op == CMD_WRB);
      wr_addr = (cmd.op == CMD_PUSH) ? count_ff[ADDR_W-1:0] : cm2[ADDR_W-1:0];
      wr_data = (cmd.op == CMD_PUSH) ? ({60'd0, sym_ff[3:0]} << FRAC_BITS) : res_ff;
      rd_en   = (cmd.op == CMD_RD_B) || (cmd.op == CMD_RD_A) || (cmd.op == CMD_RD_TOP);
      rd_addr = (cmd.op == CMD_RD_A) ? cm2[ADDR_W-1:0] : cm1[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= ST_OK;
         mbusy_ff <= 1'b0;
         mpv_ff   <= 1'b0;
         dbusy_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            CMD_LOAD: begin
               sym_ff  <= req_symbol;
               last_ff <= req_last;
            end
            CMD_PUSH:     count_ff <= count_ff + CNT_W'(1);
            CMD_ERR:      err_ff   <= cmd.code;
            CMD_RD_A:     b_ff     <= rd_ff;
            CMD_LATCH_A: begin
               a_ff   <= rd_ff;
               sat_ff <= 1'b0;
            end
            CMD_ADD: begin
               res_ff <= add_ovf ? (a_ff[DATA_W-1] ? S_MIN : S_MAX) : sum;
               sat_ff <= sat_ff | add_ovf;
            end
            CMD_SUB: begin
               res_ff <= sub_ovf ? (a_ff[DATA_W-1] ? S_MIN : S_MAX) : dif;
               sat_ff <= sat_ff | sub_ovf;
            end
            CMD_POW_INIT: begin
               acc_ff  <= FX_ONE;
               sq_ff   <= a_ff;
               nm_ff   <= mag(n_val);
               nneg_ff <= b_ff[DATA_W-1];
            end
            CMD_TAKE_MRES: res_ff <= mres_ff;
            CMD_TAKE_DRES: res_ff <= dres_ff;
            CMD_TAKE_ACC:  acc_ff <= mres_ff;
            CMD_TAKE_SQ:   sq_ff  <= mres_ff;
            CMD_NM_SHIFT:  nm_ff  <= nm_ff >> 1;
            CMD_ACC_RES:   res_ff <= acc_ff;
            CMD_WRB: begin
               count_ff <= count_ff - CNT_W'(1);
               if (sat_ff && (err_ff == ST_OK)) begin
                  err_ff <= ST_SATURATED;
               end
            end
            CMD_LATCH_TOP: res_ff <= rd_ff;
            CMD_OUT: begin
               value_ff  <= hard ? '0 : res_ff;
               status_ff <= err_ff;
               count_ff  <= '0;
               err_ff    <= ST_OK;
            end
            default: ;
         endcase

         // Multiplier sequencing.
         if ((cmd.op == CMD_MUL_AB) || (cmd.op == CMD_MUL_ACC) || (cmd.op == CMD_MUL_SQ)) begin
            mx_ff     <= mag(mx_sel);
            my_ff     <= mag(my_sel);
            mneg_ff   <= mx_sel[DATA_W-1] ^ my_sel[DATA_W-1];
            macc_ff   <= '0;
            mphase_ff <= '0;
            mpv_ff    <= 1'b0;
            mbusy_ff  <= 1'b1;
         end else if (mbusy_ff) begin
            mphase_ff <= mphase_ff + 3'd1;
            mpv_ff    <= mphase_ff < 3'd4;
            if (mphase_ff < 3'd4) begin
               pp_ff  <= pp_in;
               psh_ff <= {1'b0, mphase_ff[1]} + {1'b0, mphase_ff[0]};
            end
            if (mphase_ff == 3'd5) begin
               macc_ff <= macc_ff + MUL_RND;
            end else if (mpv_ff) begin
               macc_ff <= macc_ff + pp_sh;
            end
            if (mphase_ff == 3'd6) begin
               mres_ff  <= pk_m.val;
               sat_ff   <= sat_ff | pk_m.sat;
               mbusy_ff <= 1'b0;
            end
         end

         // Divider sequencing.
         if ((cmd.op == CMD_DIV_AB) || (cmd.op == CMD_DIV_POW)) begin
            num_ff   <= {64'd0, mag(dx_sel)} << FRAC_BITS;
            nb_ff    <= mag(dy_sel);
            dneg_ff  <= dx_sel[DATA_W-1] ^ dy_sel[DATA_W-1];
            rem_ff   <= '0;
            dcnt_ff  <= '0;
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
            if (dcnt_ff < DCNT_W'(PROD_W)) begin
               rem_ff <= ge ? DATA_W'(r2 - {1'b0, nb_ff}) : r2[DATA_W-1:0];
               num_ff <= {num_ff[PROD_W-2:0], ge};
            end else if (dcnt_ff == DCNT_W'(PROD_W)) begin
               if ({rem_ff, 1'b0} >= {1'b0, nb_ff}) begin
                  num_ff <= num_ff + PROD_W'(1);
               end
            end else begin
               dres_ff  <= pk_d.val;
               sat_ff   <= sat_ff | pk_d.sat;
               dbusy_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

### sv/pee_ctrl.sv
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences one request at a time through decode, operate and write-back.
// ----------------------------------------------------------------------------
module pee_ctrl import pee_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_RDA, S_RDB, S_EXEC, S_MULW_R, S_MULW_ACC, S_MULW_SQ,
      S_DIVW, S_POWT, S_POWS, S_POWQ, S_POWE, S_WRB, S_FIN, S_TOPW, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: CMD_NONE, code: ST_OK};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FIN;
            if (stat.hard) begin
               cmd.op = CMD_NONE;
            end else if (stat.digit) begin
               if (stat.full) begin
                  cmd = '{op: CMD_ERR, code: ST_OVERFLOW};
               end else begin
                  cmd.op = CMD_PUSH;
               end
            end else if (stat.lt2) begin
               cmd = '{op: CMD_ERR, code: ST_UNDERFLOW};
            end else begin
               cmd.op   = CMD_RD_B;
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            cmd.op   = CMD_RD_A;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = CMD_LATCH_A;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIN;
            unique case (stat.kind)
               K_ADD: begin cmd.op = CMD_ADD; state_in = S_WRB; end
               K_SUB: begin cmd.op = CMD_SUB; state_in = S_WRB; end
               K_MUL: begin cmd.op = CMD_MUL_AB; state_in = S_MULW_R; end
               K_DIV: begin
                  if (stat.b_zero) begin
                     cmd = '{op: CMD_ERR, code: ST_DIV_ZERO};
                  end else begin
                     cmd.op   = CMD_DIV_AB;
                     state_in = S_DIVW;
                  end
               end
               K_POW: begin
                  if (stat.e_frac) begin
                     cmd = '{op: CMD_ERR, code: ST_FRAC_EXP};
                  end else begin
                     cmd.op   = CMD_POW_INIT;
                     state_in = S_POWT;
                  end
               end
               default: cmd = '{op: CMD_ERR, code: ST_ILLEGAL};
            endcase
         end
         S_MULW_R: begin
            if (!stat.mul_busy) begin
               cmd.op   = CMD_TAKE_MRES;
               state_in = S_WRB;
            end
         end
         S_DIVW: begin
            if (!stat.div_busy) begin
               cmd.op   = CMD_TAKE_DRES;
               state_in = S_WRB;
            end
         end
         S_POWT: begin
            priority if (stat.nm_zero) begin
               state_in = S_POWE;
            end else if (stat.nm_odd) begin
               cmd.op   = CMD_MUL_ACC;
               state_in = S_MULW_ACC;
            end else begin
               state_in = S_POWS;
            end
         end
         S_MULW_ACC: begin
            if (!stat.mul_busy) begin
               cmd.op   = CMD_TAKE_ACC;
               state_in = S_POWS;
            end
         end
         S_POWS: begin
            cmd.op   = CMD_NM_SHIFT;
            state_in = S_POWQ;
         end
         S_POWQ: begin
            if (stat.nm_zero) begin
               state_in = S_POWE;
            end else begin
               cmd.op   = CMD_MUL_SQ;
               state_in = S_MULW_SQ;
            end
         end
         S_MULW_SQ: begin
            if (!stat.mul_busy) begin
               cmd.op   = CMD_TAKE_SQ;
               state_in = S_POWT;
            end
         end
         S_POWE: begin
            priority if (stat.n_neg && stat.acc_zero) begin
               cmd      = '{op: CMD_ERR, code: ST_DIV_ZERO};
               state_in = S_FIN;
            end else if (stat.n_neg) begin
               cmd.op   = CMD_DIV_POW;
               state_in = S_DIVW;
            end else begin
               cmd.op   = CMD_ACC_RES;
               state_in = S_WRB;
            end
         end
         S_WRB: begin
            cmd.op   = CMD_WRB;
            state_in = S_FIN;
         end
         S_FIN: begin
            priority if (!stat.last) begin
               state_in = S_IDLE;
            end else if (stat.hard) begin
               state_in = S_OUT;
            end else if (stat.cnt_zero) begin
               cmd      = '{op: CMD_ERR, code: ST_UNDERFLOW};
               state_in = S_OUT;
            end else begin
               cmd.op   = CMD_RD_TOP;
               state_in = S_TOPW;
            end
         end
         S_TOPW: begin
            cmd.op   = CMD_LATCH_TOP;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.op   = CMD_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/pee_checker.sv
// ----------------------------------------------------------------------------
// Postfix evaluator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic [2:0]  rsp_status
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Status codes above fractional exponent are never produced.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 3'd7)
      else $error("undefined status code");

   // A hard error always returns a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != 3'd0) && (rsp_status != 3'd4) |-> rsp_value == 64'd0)
      else $error("nonzero value with error status");

   // A request that is not the last one cannot produce a result next cycle.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> !$rose(rsp_valid))
      else $error("result without final request");

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_last   (req_last),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
